FILE: rtl/core/muart_pkg.sv
// Shared types and constants for the serial receive path with its FIFO.
// Used by muart_fifo and midi_uart_receiver_with_fifo; depends on nothing else.

package muart_pkg;

	localparam int FIFO_DEPTH = 256;
	localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Bus offsets
	localparam logic [7:0] OFS_CONTROL = 8'h04;
	localparam logic [7:0] OFS_STATUS  = 8'h06;
	localparam logic [7:0] OFS_RXDATA  = 8'h07;

	// Control and status codes
	localparam logic [7:0] MASTER_RESET = 8'h03;
	localparam logic [7:0] ST_RDRF      = 8'h01;
	localparam logic [7:0] ST_ENABLED   = 8'h02;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_RX    = 2'd2,
		KIND_TICK  = 2'd3
	} kind_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} fifo_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

FILE: rtl/core/muart_fifo.sv
// Receive ring FIFO: one memory, write and read pointers, fill count.
// The head entry is prefetched into a register. Depends on muart_pkg.

module muart_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  muart_pkg::fifo_ctl_t   ctl,
	input  logic [7:0]             wdata,
	output logic [7:0]             head,
	output muart_pkg::fifo_stat_t  stat
);

	logic [7:0] mem [muart_pkg::FIFO_DEPTH];

	logic [muart_pkg::FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
	logic [muart_pkg::FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
	logic [muart_pkg::FIFO_CW-1:0] count_q, count_d;
	logic [7:0]                    head_q;

	function automatic logic [muart_pkg::FIFO_AW-1:0] ptr_next(
		input logic [muart_pkg::FIFO_AW-1:0] p
	);
		if (p == muart_pkg::FIFO_AW'(muart_pkg::FIFO_DEPTH - 1))
			return '0;
		return p + muart_pkg::FIFO_AW'(1);
	endfunction

	always_comb begin
		wr_ptr_d = wr_ptr_q;
		rd_ptr_d = rd_ptr_q;
		count_d  = count_q;
		if (ctl.clear) begin
			wr_ptr_d = '0;
			rd_ptr_d = '0;
			count_d  = '0;
		end else if (ctl.push) begin
			wr_ptr_d = ptr_next(wr_ptr_q);
			count_d  = count_q + muart_pkg::FIFO_CW'(1);
		end else if (ctl.pop) begin
			rd_ptr_d = ptr_next(rd_ptr_q);
			count_d  = count_q - muart_pkg::FIFO_CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_d;
			rd_ptr_q <= rd_ptr_d;
			count_q  <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push)
			mem[wr_ptr_q] <= wdata;
	end

	// Prefetch the entry at the next read pointer; forward a write to that same entry
	always_ff @(posedge clk) begin
		if (ctl.push && (wr_ptr_q == rd_ptr_d))
			head_q <= wdata;
		else
			head_q <= mem[rd_ptr_d];
	end

	assign head       = head_q;
	assign stat.full  = (count_q == muart_pkg::FIFO_CW'(muart_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

FILE: rtl/core/midi_uart_receiver_with_fifo.sv
// Receive side of an ACIA-style serial port with a 256-entry receive FIFO.
// Depends on muart_pkg and muart_fifo.

// One request is taken every clock cycle when the result side keeps up; each
// request gives exactly one result, registered in the input register and then
// the result register. The FIFO memory has one write and one read port; its
// head entry is prefetched into a register so a tick moves it into the data
// register without waiting on the memory. FIFO contents need no clearing after
// reset: the fill count guards every read. A result waiting on a stalled output
// does not block the next request from entering the input register.

module midi_uart_receiver_with_fifo (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [7:0] offset,
	input  logic [7:0] data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       irq_line,
	output logic       byte_dropped
);

	// Input register
	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] offset_s1;
	logic [7:0] data_s1;

	// Port state
	logic [7:0] status_q, status_d;
	logic [7:0] rx_data_q, rx_data_d;
	logic       rx_full_q, rx_full_d;
	logic       irq_q, irq_d;

	// Result register
	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic       irq_line_q;
	logic       byte_dropped_q;

	logic                  out_free;
	logic                  fire_s1;
	logic                  in_take;
	logic [7:0]            rd_d;
	logic                  dropped_d;
	muart_pkg::fifo_ctl_t  fctl;
	muart_pkg::fifo_stat_t fstat;
	logic [7:0]            fhead;

	assign out_free = !out_valid_q || !out_stall;
	assign fire_s1  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_take)
			valid_s1 <= 1'b1;
		else if (fire_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1   <= kind;
			offset_s1 <= offset;
			data_s1   <= data;
		end
	end

	always_comb begin
		status_d   = status_q;
		rx_data_d  = rx_data_q;
		rx_full_d  = rx_full_q;
		irq_d      = irq_q;
		rd_d       = '0;
		dropped_d  = 1'b0;
		fctl.push  = 1'b0;
		fctl.pop   = 1'b0;
		fctl.clear = 1'b0;
		case (muart_pkg::kind_t'(kind_s1))
			muart_pkg::KIND_READ: begin
				if (offset_s1 == muart_pkg::OFS_STATUS) begin
					rd_d = status_q;
				end else if (offset_s1 == muart_pkg::OFS_RXDATA) begin
					rd_d      = rx_data_q;
					rx_full_d = 1'b0;
					status_d  = status_q & ~muart_pkg::ST_RDRF;
					irq_d     = 1'b0;
				end
			end
			muart_pkg::KIND_WRITE: begin
				if (offset_s1 == muart_pkg::OFS_CONTROL) begin
					if (data_s1 == muart_pkg::MASTER_RESET) begin
						status_d   = '0;
						rx_full_d  = 1'b0;
						irq_d      = 1'b0;
						fctl.clear = fire_s1;
					end else begin
						status_d = muart_pkg::ST_ENABLED;
					end
				end
			end
			muart_pkg::KIND_RX: begin
				if (fstat.full)
					dropped_d = 1'b1;
				else
					fctl.push = fire_s1;
			end
			muart_pkg::KIND_TICK: begin
				if (!rx_full_q && !fstat.empty) begin
					rx_data_d = fhead;
					fctl.pop  = fire_s1;
					rx_full_d = 1'b1;
					status_d  = status_q | muart_pkg::ST_RDRF;
					irq_d     = 1'b1;
				end
			end
			default: begin
				rd_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= '0;
			rx_data_q <= '0;
			rx_full_q <= 1'b0;
			irq_q     <= 1'b0;
		end else if (fire_s1) begin
			status_q  <= status_d;
			rx_data_q <= rx_data_d;
			rx_full_q <= rx_full_d;
			irq_q     <= irq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			read_data_q    <= rd_d;
			irq_line_q     <= irq_d;
			byte_dropped_q <= dropped_d;
		end
	end

	muart_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fctl),
		.wdata  (data_s1),
		.head   (fhead),
		.stat   (fstat)
	);

	assign out_valid    = out_valid_q;
	assign read_data    = read_data_q;
	assign irq_line     = irq_line_q;
	assign byte_dropped = byte_dropped_q;

	// The interrupt follows the receive-full flag exactly
	a_irq_tracks_full: assert property (@(posedge clk) disable iff (!arst_n)
		irq_q == rx_full_q)
		else $error("interrupt and receive-full flag disagree");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && (kind_s1 == muart_pkg::KIND_RX) && fstat.full)
		|=> (out_valid_q && byte_dropped_q))
		else $error("byte into a full FIFO not reported as dropped");

	a_tick_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && (kind_s1 == muart_pkg::KIND_TICK) && !rx_full_q && !fstat.empty)
		|=> (rx_full_q && irq_q && status_q[0]))
		else $error("tick with pending data did not load the data register");

endmodule

FILE: tb/midi_uart_receiver_with_fifo_tb.sv
// Self-checking bench for the ACIA-style receive path with its receive FIFO.
// Depends on muart_pkg and midi_uart_receiver_with_fifo; predicts every reply in-line.
`timescale 1ns / 100ps

module midi_uart_receiver_with_fifo_tb;

	localparam logic [7:0] OFS_TXDATA = 8'h05;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [7:0] rd;
		logic       irq;
		logic       dropped;
	} acia_reply_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] kind;
	logic [7:0] offset;
	logic [7:0] data;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] read_data;
	logic       irq_line;
	logic       byte_dropped;

	// mirror of the port state
	logic [7:0] ctrl_reg;
	logic [7:0] stat_reg;
	logic [7:0] rx_hold;
	logic       rx_full;
	logic       irq_on;
	logic [7:0] rx_ring [muart_pkg::FIFO_DEPTH];
	int         ring_wr;
	int         ring_rd;
	int         ring_fill;

	acia_reply_t bus_replies [$];
	acia_reply_t got_reply;
	int          fail_count;
	int          quiet_cycles;
	bit          idle_on;
	int          hold_left;
	int          stall_left;

	midi_uart_receiver_with_fifo u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.offset      (offset),
		.data        (data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.irq_line    (irq_line),
		.byte_dropped(byte_dropped)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int ring_next(int p);
		return (p + 1 >= muart_pkg::FIFO_DEPTH) ? 0 : p + 1;
	endfunction

	function automatic acia_reply_t acia_rx_next(muart_pkg::kind_t k, logic [7:0] ofs,
		logic [7:0] dat);
		acia_reply_t r;
		r = '0;
		case (k)
			muart_pkg::KIND_READ: begin
				if (ofs == muart_pkg::OFS_STATUS) begin
					r.rd = stat_reg;
				end else if (ofs == muart_pkg::OFS_RXDATA) begin
					r.rd = rx_hold;
					rx_full = 1'b0;
					stat_reg = stat_reg & ~muart_pkg::ST_RDRF;
					irq_on = 1'b0;
				end
			end
			muart_pkg::KIND_WRITE: begin
				if (ofs == muart_pkg::OFS_CONTROL) begin
					ctrl_reg = dat;
					if (dat == muart_pkg::MASTER_RESET) begin
						stat_reg = '0;
						rx_full = 1'b0;
						irq_on = 1'b0;
						ring_wr = 0;
						ring_rd = 0;
						ring_fill = 0;
					end else begin
						stat_reg = muart_pkg::ST_ENABLED;
					end
				end
			end
			muart_pkg::KIND_RX: begin
				if (ring_fill >= muart_pkg::FIFO_DEPTH) begin
					r.dropped = 1'b1;
				end else begin
					rx_ring[ring_wr] = dat;
					ring_wr = ring_next(ring_wr);
					ring_fill++;
				end
			end
			default: begin
				if (!rx_full && ring_fill > 0) begin
					rx_hold = rx_ring[ring_rd];
					ring_rd = ring_next(ring_rd);
					ring_fill--;
					rx_full = 1'b1;
					stat_reg = stat_reg | muart_pkg::ST_RDRF;
					irq_on = 1'b1;
				end
			end
		endcase
		r.irq = irq_on;
		return r;
	endfunction

	// Offer one request, hold it until taken, then log its reply.
	task automatic send_request(input muart_pkg::kind_t k, input logic [7:0] ofs,
		input logic [7:0] dat);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 11);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		offset <= ofs;
		data <= dat;
		do @(posedge clk); while (in_stall);
		bus_replies.push_back(acia_rx_next(k, ofs, dat));
	endtask

	task automatic send_random_request();
		send_request(muart_pkg::kind_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
	endtask

	task automatic test_register_map();
		send_request(muart_pkg::KIND_READ, muart_pkg::OFS_STATUS, 8'h00);
		send_request(muart_pkg::KIND_READ, muart_pkg::OFS_RXDATA, 8'hFF);	// nothing pending: stale data
		send_request(muart_pkg::KIND_READ, 8'hFF, 8'h00);
		send_request(muart_pkg::KIND_READ, 8'h00, 8'hFF);
		send_request(muart_pkg::KIND_TICK, 8'h00, 8'h00);		// FIFO empty
		send_request(muart_pkg::KIND_WRITE, muart_pkg::OFS_CONTROL, 8'h00);
		send_request(muart_pkg::KIND_WRITE, OFS_TXDATA, 8'hFF);
		send_request(muart_pkg::KIND_WRITE, 8'hFF, 8'hAA);
		send_request(muart_pkg::KIND_RX, 8'h00, 8'hFF);
		send_request(muart_pkg::KIND_RX, 8'hFF, 8'h00);
		send_request(muart_pkg::KIND_RX, 8'h55, 8'h5A);
		send_request(muart_pkg::KIND_TICK, 8'hFF, 8'hFF);
		send_request(muart_pkg::KIND_TICK, 8'h00, 8'h00);		// flag already set
		send_request(muart_pkg::KIND_READ, muart_pkg::OFS_STATUS, 8'h00);
		// non-reset control value: status drops bit 0, flag and irq stay
		send_request(muart_pkg::KIND_WRITE, muart_pkg::OFS_CONTROL, 8'hFF);
		send_request(muart_pkg::KIND_TICK, 8'h00, 8'h00);
		send_request(muart_pkg::KIND_READ, muart_pkg::OFS_STATUS, 8'h00);
		send_request(muart_pkg::KIND_READ, muart_pkg::OFS_RXDATA, 8'h00);
		send_request(muart_pkg::KIND_TICK, 8'h00, 8'h00);
		send_request(muart_pkg::KIND_WRITE, muart_pkg::OFS_CONTROL, muart_pkg::MASTER_RESET);
		send_request(muart_pkg::KIND_READ, muart_pkg::OFS_STATUS, 8'h00);
		send_request(muart_pkg::KIND_TICK, 8'h00, 8'h00);
		send_request(muart_pkg::KIND_READ, muart_pkg::OFS_RXDATA, 8'h00);
		send_request(muart_pkg::KIND_RX, 8'hFF, 8'h80);
		send_request(muart_pkg::KIND_TICK, 8'h00, 8'h00);
	endtask

	// Fill past capacity, then drain every entry.
	task automatic test_fifo_overflow();
		send_request(muart_pkg::KIND_WRITE, muart_pkg::OFS_CONTROL, muart_pkg::MASTER_RESET);
		send_request(muart_pkg::KIND_WRITE, muart_pkg::OFS_CONTROL, 8'($urandom));
		repeat (muart_pkg::FIFO_DEPTH + 4)
			send_request(muart_pkg::KIND_RX, 8'($urandom), 8'($urandom));
		repeat (muart_pkg::FIFO_DEPTH) begin
			send_request(muart_pkg::KIND_TICK, 8'($urandom), 8'($urandom));
			if ($urandom_range(0, 7) == 0)
				send_request(muart_pkg::KIND_READ, muart_pkg::OFS_STATUS, 8'($urandom));
			send_request(muart_pkg::KIND_READ, muart_pkg::OFS_RXDATA, 8'($urandom));
		end
	endtask

	// Receiver holds off while requests keep coming, so the input backs up.
	task automatic test_output_hold_off();
		hold_left = HOLD_CYCLES;
		repeat (40)
			send_random_request();
	endtask

	task automatic run_traffic(input int n);
		int sent;
		int burst;
		sent = 0;
		while (sent < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					burst = $urandom_range(1, 4);
					repeat (burst)
						send_request(muart_pkg::KIND_RX, 8'($urandom), 8'($urandom));
					sent += burst;
					burst = $urandom_range(1, 4);
					repeat (burst) begin
						send_request(muart_pkg::KIND_TICK, 8'($urandom), 8'($urandom));
						send_request(muart_pkg::KIND_READ, muart_pkg::OFS_STATUS,
							8'($urandom));
						send_request(muart_pkg::KIND_READ, muart_pkg::OFS_RXDATA,
							8'($urandom));
					end
					sent += 3 * burst;
				end
				6: begin
					send_request(muart_pkg::KIND_WRITE, muart_pkg::OFS_CONTROL,
						($urandom_range(0, 7) == 0) ? muart_pkg::MASTER_RESET
							: 8'($urandom));
					sent++;
				end
				7: begin
					send_request(muart_pkg::KIND_WRITE,
						($urandom_range(0, 1) == 0) ? OFS_TXDATA : 8'($urandom),
						8'($urandom));
					sent++;
				end
				default: begin
					send_random_request();
					sent++;
				end
			endcase
		end
	endtask

	task automatic test_random_traffic();
		run_traffic(350);
	endtask

	task automatic test_full_rate();
		idle_on = 1'b0;
		run_traffic(200);
	endtask

	// Result side: random stall bursts, no stalls in the full-rate test, or a long hold when requested.
	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (!idle_on) begin
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if ($urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(0, 10);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (bus_replies.size() == 0) begin
				$error("reply with no request outstanding: read_data %0h irq %0b dropped %0b",
					read_data, irq_line, byte_dropped);
				fail_count++;
			end else begin
				got_reply = bus_replies.pop_front();
				if (read_data !== got_reply.rd) begin
					$error("read_data: expected %0h, got %0h", got_reply.rd, read_data);
					fail_count++;
				end
				if (irq_line !== got_reply.irq) begin
					$error("irq_line: expected %0b, got %0b", got_reply.irq, irq_line);
					fail_count++;
				end
				if (byte_dropped !== got_reply.dropped) begin
					$error("byte_dropped: expected %0b, got %0b", got_reply.dropped,
						byte_dropped);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: abort after a long stretch with no handshake on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = muart_pkg::KIND_READ;
		offset = '0;
		data = '0;
		idle_on = 1'b1;
		hold_left = 0;
		fail_count = 0;
		quiet_cycles = 0;
		ctrl_reg = '0;
		stat_reg = '0;
		rx_hold = '0;
		rx_full = 1'b0;
		irq_on = 1'b0;
		ring_wr = 0;
		ring_rd = 0;
		ring_fill = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_register_map();
		test_fifo_overflow();
		test_output_hold_off();
		test_random_traffic();
		test_full_rate();

		@(negedge clk);
		in_valid <= 1'b0;
		while (bus_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/muart_pkg.sv
rtl/core/muart_fifo.sv
rtl/core/midi_uart_receiver_with_fifo.sv
tb/midi_uart_receiver_with_fifo_tb.sv
